// ===== hdl/lrup_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrup_pkg: shared types and constants for the LRU page replacement block
// Field widths, opcodes, reset values and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package lrup_pkg;

	// Default sizing
	localparam int FRAMES_DEF    = 8;
	localparam int PAGE_BITS_DEF = 16;

	// Fixed port field widths
	localparam int CFG_W   = 4;
	localparam int PAGE_W  = 16;
	localparam int IDX_W   = 3;
	localparam int COUNT_W = 16;

	localparam logic [CFG_W-1:0]   ACTIVE_RESET = 4'd8;
	localparam logic [COUNT_W-1:0] COUNT_MAX    = 16'hFFFF;

	// Request opcodes
	localparam logic OP_RESTART = 1'b1;

	// Controller to datapath commands
	typedef struct packed {
		logic load;       // latch request, start scan
		logic scan_step;  // examine one frame
		logic commit;     // update state, write result register
	} lrup_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic scan_done;  // hit found or last active frame examined
		logic slot_free;  // result register can take a new result
	} lrup_sts_t;

endpackage
`default_nettype wire

// ===== hdl/lrup_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrup_ifs: request and response stream interfaces
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface lrup_req_if;
	logic                         valid;
	logic                         ready;
	logic                         opcode;
	logic [lrup_pkg::PAGE_W-1:0]  page_number;

	modport source (output valid, output opcode, output page_number, input ready);
	modport sink   (input valid, input opcode, input page_number, output ready);
endinterface

interface lrup_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         hit;
	logic [lrup_pkg::IDX_W-1:0]   frame_index;
	logic                         evicted_valid;
	logic [lrup_pkg::PAGE_W-1:0]  evicted_page;
	logic [lrup_pkg::COUNT_W-1:0] fault_count;

	modport source (output valid, output hit, output frame_index, output evicted_valid,
		output evicted_page, output fault_count, input ready);
	modport sink   (input valid, input hit, input frame_index, input evicted_valid,
		input evicted_page, input fault_count, output ready);
endinterface
`default_nettype wire

// ===== hdl/lrup_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrup_ctrl: sequencing controller
// Accepts one request, steps the frame scan, then commits once the result
// register is free.
// ----------------------------------------------------------------------------
module lrup_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  lrup_pkg::lrup_sts_t sts,
	output lrup_pkg::lrup_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	state_t state_q;
	logic   in_ready_q;

	assign in_ready = in_ready_q;

	// Commands decoded from state
	always_comb begin
		cmd.load      = in_valid && in_ready_q;
		cmd.scan_step = (state_q == ST_SCAN);
		cmd.commit    = (state_q == ST_UPDATE) && sts.slot_free;
	end

	// State and registered ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready_q) begin
						state_q    <= ST_SCAN;
						in_ready_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (sts.scan_done) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (sts.slot_free) begin
						state_q    <= ST_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= ST_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end

	// One request in flight at a time
	a_load_closes_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !in_ready_q)
		else $error("ready still high after request transfer");

	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready_q |-> (state_q == ST_IDLE))
		else $error("ready high outside idle");

endmodule
`default_nettype wire

// ===== hdl/lrup_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrup_dp: frame table, recency ranks and result register
// Scans one frame per cycle for a hit, the first empty frame and the oldest
// frame; the commit cycle ages the younger active ranks in parallel and writes the result.
// ----------------------------------------------------------------------------
module lrup_dp #(
	parameter int FRAMES    = lrup_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = lrup_pkg::PAGE_BITS_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_wr_en,
	input  wire  [lrup_pkg::CFG_W-1:0]    cfg_wr_data,
	input  wire                           in_opcode,
	input  wire  [lrup_pkg::PAGE_W-1:0]   in_page_number,
	input  lrup_pkg::lrup_cmd_t           cmd,
	output lrup_pkg::lrup_sts_t           sts,
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic                          out_hit,
	output logic [lrup_pkg::IDX_W-1:0]    out_frame_index,
	output logic                          out_evicted_valid,
	output logic [lrup_pkg::PAGE_W-1:0]   out_evicted_page,
	output logic [lrup_pkg::COUNT_W-1:0]  out_fault_count
);

	localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam logic [IW-1:0] RANK_MAX = IW'(FRAMES - 1);
	localparam logic [4:0]    FRAMES_5 = 5'(FRAMES);

	// Architectural state
	logic [lrup_pkg::CFG_W-1:0]   active_q;
	logic [FRAMES-1:0]            valid_q;
	logic [IW-1:0]                rank_q [FRAMES];
	logic [PAGE_BITS-1:0]         page_q [FRAMES];
	logic [lrup_pkg::COUNT_W-1:0] fault_q;

	// Request and scan trackers
	logic                 req_restart_q;
	logic [PAGE_BITS-1:0] req_page_q;
	logic [IW-1:0]        idx_q;
	logic                 match_q;
	logic [IW-1:0]        match_f_q;
	logic [IW-1:0]        match_rank_q;
	logic                 empty_q;
	logic [IW-1:0]        empty_f_q;
	logic [IW-1:0]        oldest_rank_q;
	logic [IW-1:0]        oldest_f_q;
	logic [PAGE_BITS-1:0] oldest_page_q;

	// Result register
	logic                         out_valid_q;
	logic                         out_hit_q;
	logic [lrup_pkg::IDX_W-1:0]   out_idx_q;
	logic                         out_ev_valid_q;
	logic [lrup_pkg::PAGE_W-1:0]  out_ev_page_q;
	logic [lrup_pkg::COUNT_W-1:0] out_fault_q;

	logic [IW-1:0]                last_idx;
	logic                         cur_valid;
	logic [IW-1:0]                cur_rank;
	logic [PAGE_BITS-1:0]         cur_page;
	logic                         cur_match;
	logic                         scan_done;
	logic [IW-1:0]                sel_f;
	logic                         age_all;
	logic [IW-1:0]                age_limit;
	logic                         evict;
	logic [lrup_pkg::COUNT_W-1:0] fault_next;
	logic [FRAMES-1:0]            valid_next;
	logic [IW-1:0]                rank_next [FRAMES];
	logic [PAGE_BITS+15:0]        in_page_ext;
	logic [PAGE_BITS+15:0]        ev_page_ext;
	logic [IW+2:0]                sel_f_ext;

	// Last active frame index, active count clamped to 1..FRAMES
	always_comb begin
		if (active_q == '0) begin
			last_idx = '0;
		end else if ({1'b0, active_q} > FRAMES_5) begin
			last_idx = IW'(FRAMES - 1);
		end else begin
			last_idx = IW'(active_q - 4'd1);
		end
	end

	// Current scan frame
	assign cur_valid = valid_q[idx_q];
	assign cur_rank  = rank_q[idx_q];
	assign cur_page  = page_q[idx_q];
	assign cur_match = cur_valid && (cur_page == req_page_q);
	assign scan_done = cur_match || (idx_q == last_idx);

	assign sts.scan_done = scan_done;
	assign sts.slot_free = !out_valid_q || out_ready;

	// Page width adaptation
	assign in_page_ext = {{PAGE_BITS{1'b0}}, in_page_number};
	assign ev_page_ext = {16'h0000, oldest_page_q};
	assign sel_f_ext   = {3'b000, sel_f};

	// Commit decision
	always_comb begin
		evict     = !match_q && !empty_q;
		sel_f     = match_q ? match_f_q : (empty_q ? empty_f_q : oldest_f_q);
		age_all   = !match_q && empty_q;
		age_limit = match_q ? match_rank_q : oldest_rank_q;
		if (req_restart_q) begin
			fault_next = '0;
		end else if (match_q || (fault_q == lrup_pkg::COUNT_MAX)) begin
			fault_next = fault_q;
		end else begin
			fault_next = fault_q + 16'd1;
		end
	end

	// Per-frame rank ageing and valid update
	always_comb begin
		for (int i = 0; i < FRAMES; i++) begin
			valid_next[i] = valid_q[i];
			rank_next[i]  = rank_q[i];
			if (req_restart_q) begin
				valid_next[i] = 1'b0;
				rank_next[i]  = '0;
			end else if (IW'(i) == sel_f) begin
				valid_next[i] = 1'b1;
				rank_next[i]  = '0;
			end else if ((IW'(i) <= last_idx) && valid_q[i]
					&& (age_all || (rank_q[i] < age_limit))
					&& (rank_q[i] != RANK_MAX)) begin
				rank_next[i] = rank_q[i] + IW'(1);
			end
		end
	end

	// Control state, frame status and fault counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= lrup_pkg::ACTIVE_RESET;
			valid_q     <= '0;
			fault_q     <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < FRAMES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				active_q <= cfg_wr_data;
			end
			if (cmd.commit) begin
				valid_q     <= valid_next;
				fault_q     <= fault_next;
				out_valid_q <= 1'b1;
				for (int i = 0; i < FRAMES; i++) begin
					rank_q[i] <= rank_next[i];
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request latch and scan trackers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_restart_q <= (in_opcode == lrup_pkg::OP_RESTART);
			req_page_q    <= in_page_ext[PAGE_BITS-1:0];
			idx_q         <= '0;
			match_q       <= 1'b0;
			empty_q       <= 1'b0;
			oldest_rank_q <= '0;
			oldest_f_q    <= '0;
			oldest_page_q <= page_q[0];
		end else if (cmd.scan_step) begin
			if (cur_match && !match_q) begin
				match_q      <= 1'b1;
				match_f_q    <= idx_q;
				match_rank_q <= cur_rank;
			end
			if (!cur_valid && !empty_q) begin
				empty_q   <= 1'b1;
				empty_f_q <= idx_q;
			end
			if (cur_rank > oldest_rank_q) begin
				oldest_rank_q <= cur_rank;
				oldest_f_q    <= idx_q;
				oldest_page_q <= cur_page;
			end
			if (!scan_done) begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	// Page table write and result payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (!req_restart_q && !match_q) begin
				page_q[sel_f] <= req_page_q;
			end
			out_fault_q <= fault_next;
			if (req_restart_q) begin
				out_hit_q      <= 1'b0;
				out_idx_q      <= '0;
				out_ev_valid_q <= 1'b0;
				out_ev_page_q  <= '0;
			end else begin
				out_hit_q      <= match_q;
				out_idx_q      <= sel_f_ext[2:0];
				out_ev_valid_q <= evict;
				out_ev_page_q  <= evict ? ev_page_ext[15:0] : '0;
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign out_hit           = out_hit_q;
	assign out_frame_index   = out_idx_q;
	assign out_evicted_valid = out_ev_valid_q;
	assign out_evicted_page  = out_ev_page_q;
	assign out_fault_count   = out_fault_q;

	// A hit never evicts
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_hit_q && out_ev_valid_q))
		else $error("result reports hit and eviction together");

	// Fault count only drops on restart
	a_fault_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && !req_restart_q) |=> (fault_q >= $past(fault_q)))
		else $error("fault count decreased without restart");

	// Frames only empty on restart
	a_valid_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && !req_restart_q) |=> ($countones(valid_q) >= $past($countones(valid_q))))
		else $error("frame emptied without restart");

endmodule
`default_nettype wire

// ===== hdl/lru_page_replacement.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A reference that hits in frame k (from 0) ends its scan at frame k; a miss scans every
//   active frame, and a restart scans no further than a miss does.
// Requests are handled one at a time; the frame scan examines one frame per cycle
//   through a single table read port, and the commit waits for a free result register.
// A result register holds the finished result; a new request is taken while it waits.
// Reset (arst_n low): all frames empty, ranks and fault count zero, active_frames 8.
// ----------------------------------------------------------------------------
// lru_page_replacement: LRU page frame replacement policy
// Fully associative lookup over the active frames with rank-based recency.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
	parameter int FRAMES    = lrup_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = lrup_pkg::PAGE_BITS_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_wr_en,
	input  wire  [lrup_pkg::CFG_W-1:0] cfg_wr_data,
	lrup_req_if.sink                   req,
	lrup_rsp_if.source                 rsp
);

	lrup_pkg::lrup_cmd_t cmd;
	lrup_pkg::lrup_sts_t sts;

	// Sequencing
	lrup_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Frame table and result
	lrup_dp #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_wr_data       (cfg_wr_data),
		.in_opcode         (req.opcode),
		.in_page_number    (req.page_number),
		.cmd               (cmd),
		.sts               (sts),
		.out_valid         (rsp.valid),
		.out_ready         (rsp.ready),
		.out_hit           (rsp.hit),
		.out_frame_index   (rsp.frame_index),
		.out_evicted_valid (rsp.evicted_valid),
		.out_evicted_page  (rsp.evicted_page),
		.out_fault_count   (rsp.fault_count)
	);

endmodule
`default_nettype wire
